// ===== hdl/argbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// argbc_pkg
// Shared types, register indexes, mode codes and lane rounding for the
// premultiplied ARGB32 compositor.
// ============================================================================
package argbc_pkg;

    localparam int unsigned PIXEL_W = 32;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned LANES   = 4;
    localparam int unsigned PROD_W  = 16;

    localparam logic [1:0] MODE_OVER   = 2'd0;
    localparam logic [1:0] MODE_INTERP = 2'd1;
    localparam logic [1:0] MODE_SOLID  = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    localparam logic [1:0] CFG_MODE        = 2'd0;
    localparam logic [1:0] CFG_CONST_ALPHA = 2'd1;
    localparam logic [1:0] CFG_SOLID_COLOR = 2'd2;

    localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;
    localparam logic [16:0] ROUND_HALF   = 17'h00080;

    typedef struct packed {
        logic [31:0] src_pixel;
        logic [31:0] dst_pixel;
        logic        end_of_run;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] result_pixel;
        logic        last_of_run;
    } t_out_beat;

    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } t_pipe_ctl;

    function automatic logic [7:0] lane_round(input logic [15:0] t);
        logic [16:0] sum;
        sum = {1'b0, t} + {9'd0, t[15:8]} + ROUND_HALF;
        return sum[15:8];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/argbc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// argbc_datapath
// Four register stages: scale products, rounding, destination products,
// final rounding with byte-wise add and result selection.
// ============================================================================
module argbc_datapath (
    input  wire                    i_clk,
    input  wire argbc_pkg::t_pipe_ctl i_ctl,
    input  wire argbc_pkg::t_in_beat  i_in,
    input  wire [1:0]              i_mode,
    input  wire [7:0]              i_const_alpha,
    input  wire [31:0]             i_solid_color,
    output argbc_pkg::t_out_beat   o_out
);
    import argbc_pkg::*;

    logic [31:0]            n_color;
    logic [7:0]             n_inv_ca;
    logic [LANES-1:0][15:0] n_s1_pa;
    logic [LANES-1:0][15:0] n_s1_pb;
    logic                   n_s1_skip;
    logic [LANES-1:0][15:0] r_s1_pa;
    logic [LANES-1:0][15:0] r_s1_pb;
    logic [31:0]            r_s1_dst;
    logic [1:0]             r_s1_mode;
    logic                   r_s1_skip;
    logic                   r_s1_eor;

    logic [31:0]            n_s2_s;
    logic [31:0]            n_s2_interp;
    logic [31:0]            r_s2_s;
    logic [31:0]            r_s2_interp;
    logic [31:0]            r_s2_dst;
    logic [1:0]             r_s2_mode;
    logic                   r_s2_skip;
    logic                   r_s2_eor;

    logic [7:0]             n_inv_sa;
    logic [LANES-1:0][15:0] n_s3_prod;
    logic [LANES-1:0][15:0] r_s3_prod;
    logic [31:0]            r_s3_s;
    logic [31:0]            r_s3_interp;
    logic [31:0]            r_s3_dst;
    logic [1:0]             r_s3_mode;
    logic                   r_s3_skip;
    logic                   r_s3_eor;

    logic [31:0]            n_over;
    logic [31:0]            n_result;
    t_out_beat              r_out;

    always_comb begin
        n_color   = (i_mode == MODE_SOLID) ? i_solid_color : i_in.src_pixel;
        n_inv_ca  = ALPHA_OPAQUE - i_const_alpha;
        n_s1_skip = (i_mode == MODE_OVER) && (i_in.src_pixel[31:24] == 8'd0);
        for (int k = 0; k < LANES; k++) begin
            n_s1_pa[k] = n_color[8*k +: 8] * i_const_alpha;
            n_s1_pb[k] = i_in.dst_pixel[8*k +: 8] * n_inv_ca;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_s1_pa   <= n_s1_pa;
            r_s1_pb   <= n_s1_pb;
            r_s1_dst  <= i_in.dst_pixel;
            r_s1_mode <= i_mode;
            r_s1_skip <= n_s1_skip;
            r_s1_eor  <= i_in.end_of_run;
        end
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            n_s2_s[8*k +: 8]      = lane_round(r_s1_pa[k]);
            n_s2_interp[8*k +: 8] = lane_round(r_s1_pa[k] + r_s1_pb[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_s2_s      <= n_s2_s;
            r_s2_interp <= n_s2_interp;
            r_s2_dst    <= r_s1_dst;
            r_s2_mode   <= r_s1_mode;
            r_s2_skip   <= r_s1_skip;
            r_s2_eor    <= r_s1_eor;
        end
    end

    always_comb begin
        n_inv_sa = ALPHA_OPAQUE - r_s2_s[31:24];
        for (int k = 0; k < LANES; k++) begin
            n_s3_prod[k] = r_s2_dst[8*k +: 8] * n_inv_sa;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            r_s3_prod   <= n_s3_prod;
            r_s3_s      <= r_s2_s;
            r_s3_interp <= r_s2_interp;
            r_s3_dst    <= r_s2_dst;
            r_s3_mode   <= r_s2_mode;
            r_s3_skip   <= r_s2_skip;
            r_s3_eor    <= r_s2_eor;
        end
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            n_over[8*k +: 8] = r_s3_s[8*k +: 8] + lane_round(r_s3_prod[k]);
        end
        case (r_s3_mode)
            MODE_OVER:   n_result = r_s3_skip ? r_s3_dst : n_over;
            MODE_INTERP: n_result = r_s3_interp;
            MODE_SOLID:  n_result = n_over;
            default:     n_result = r_s3_dst;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld4) begin
            r_out.result_pixel <= n_result;
            r_out.last_of_run  <= r_s3_eor;
        end
    end

    assign o_out = r_out;

endmodule
`default_nettype wire

// ===== hdl/argb_premultiplied_compositor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// argb_premultiplied_compositor
// Composites premultiplied ARGB32 pixels in source-over, interpolate or
// solid-color source-over mode, or passes the destination through.
// ============================================================================
// The block takes one pixel beat per clock while its output is not stalled.
// It presents the results on its output in order, one result per input beat.
// Each beat passes through four register stages, the first of which captures
// the beat at the accepting edge: source scaling products, their rounding,
// destination products, and the final rounding with byte add. A stalled
// output holds the pipeline, and input is refused only when all four stages
// are full. The user must write the configuration registers through a plain
// write port while the block is idle; the block itself does not enforce it.
module argb_premultiplied_compositor (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  wire [1:0]               i_cfg_idx,
    input  wire [31:0]              i_cfg_data,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  wire argbc_pkg::t_in_beat i_in,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output argbc_pkg::t_out_beat    o_out
);
    import argbc_pkg::*;

    logic [1:0]  r_mode;
    logic [7:0]  r_const_alpha;
    logic [31:0] r_solid_color;
    logic        r_v1;
    logic        r_v2;
    logic        r_v3;
    logic        r_v4;
    t_pipe_ctl   n_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_OVER;
            r_const_alpha <= ALPHA_OPAQUE;
            r_solid_color <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:        r_mode        <= i_cfg_data[1:0];
                CFG_CONST_ALPHA: r_const_alpha <= i_cfg_data[7:0];
                CFG_SOLID_COLOR: r_solid_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_ctl.ld4 = !r_v4 || i_out_ready;
        n_ctl.ld3 = !r_v3 || n_ctl.ld4;
        n_ctl.ld2 = !r_v2 || n_ctl.ld3;
        n_ctl.ld1 = !r_v1 || n_ctl.ld2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (n_ctl.ld1) begin
                r_v1 <= i_in_valid;
            end
            if (n_ctl.ld2) begin
                r_v2 <= r_v1;
            end
            if (n_ctl.ld3) begin
                r_v3 <= r_v2;
            end
            if (n_ctl.ld4) begin
                r_v4 <= r_v3;
            end
        end
    end

    argbc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_ctl         (n_ctl),
        .i_in          (i_in),
        .i_mode        (r_mode),
        .i_const_alpha (r_const_alpha),
        .i_solid_color (r_solid_color),
        .o_out         (o_out)
    );

    assign o_in_ready  = n_ctl.ld1;
    assign o_out_valid = r_v4;

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_v1 && r_v2 && r_v3 && r_v4))
        else $error("Input blocked while the pipeline has a free stage.");

    a_stage3_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && n_ctl.ld4) |=> r_v4)
        else $error("A beat leaving stage three was lost.");

    a_stage1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !n_ctl.ld2) |=> r_v1)
        else $error("A stalled beat in stage one was dropped.");

endmodule
`default_nettype wire

// ===== verif/argbc_pixel_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// argbc_pixel_checker
// Watches the configuration port and both pixel channels of the compositor,
// keeps its own copy of the registers, predicts each composited pixel when a
// beat is accepted and compares every result beat against the oldest
// prediction, field by field.
// ============================================================================
module argbc_pixel_checker (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_we,
    input  wire [1:0]                i_cfg_idx,
    input  wire [31:0]               i_cfg_data,
    input  wire                      i_in_valid,
    input  wire                      i_in_ready,
    input  wire argbc_pkg::t_in_beat  i_in,
    input  wire                      i_out_valid,
    input  wire                      i_out_ready,
    input  wire argbc_pkg::t_out_beat i_out,
    output int                       o_errors,
    output int                       o_pending,
    output int                       o_checked
);
    import argbc_pkg::*;

    logic [1:0]  blend_mode;
    logic [7:0]  global_alpha;
    logic [31:0] fill_color;
    t_out_beat   expected_pixels[$];

    function automatic logic [7:0] round_lane(input int unsigned t);
        return 8'((t + (t >> 8) + 128) >> 8);
    endfunction

    function automatic logic [31:0] scale_pixel(input logic [31:0] px, input logic [7:0] a);
        logic [31:0] r;
        for (int k = 0; k < 4; k++) begin
            r[8*k +: 8] = round_lane(int'(px[8*k +: 8]) * int'(a));
        end
        return r;
    endfunction

    function automatic logic [31:0] mix_pixels(input logic [31:0] s, input logic [31:0] d,
                                               input logic [7:0] a);
        logic [31:0] r;
        for (int k = 0; k < 4; k++) begin
            r[8*k +: 8] = round_lane(int'(s[8*k +: 8]) * int'(a)
                                     + int'(d[8*k +: 8]) * (255 - int'(a)));
        end
        return r;
    endfunction

    function automatic logic [31:0] add_wrap(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] r;
        for (int k = 0; k < 4; k++) begin
            r[8*k +: 8] = x[8*k +: 8] + y[8*k +: 8];
        end
        return r;
    endfunction

    function automatic logic [31:0] blend_over(input logic [31:0] s, input logic [31:0] d);
        return add_wrap(s, scale_pixel(d, ALPHA_OPAQUE - s[31:24]));
    endfunction

    function automatic logic [31:0] composite_pixel(input logic [31:0] src,
                                                    input logic [31:0] dst);
        logic [31:0] res;
        logic [31:0] top;
        res = dst;
        case (blend_mode)
            MODE_OVER: begin
                if (src[31:24] != 8'h00) begin
                    top = (global_alpha != ALPHA_OPAQUE) ? scale_pixel(src, global_alpha) : src;
                    res = blend_over(top, dst);
                end
            end
            MODE_INTERP: begin
                res = (global_alpha == ALPHA_OPAQUE) ? src : mix_pixels(src, dst, global_alpha);
            end
            MODE_SOLID: begin
                if ((global_alpha & fill_color[31:24]) == ALPHA_OPAQUE) begin
                    res = fill_color;
                end else begin
                    top = (global_alpha != ALPHA_OPAQUE) ?
                          scale_pixel(fill_color, global_alpha) : fill_color;
                    res = blend_over(top, dst);
                end
            end
            default: res = dst;
        endcase
        return res;
    endfunction

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
    end

    always @(posedge i_clk) begin : watch
        t_out_beat want;
        if (!i_rst_n) begin
            blend_mode   <= MODE_OVER;
            global_alpha <= ALPHA_OPAQUE;
            fill_color   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:        blend_mode   <= i_cfg_data[1:0];
                CFG_CONST_ALPHA: global_alpha <= i_cfg_data[7:0];
                CFG_SOLID_COLOR: fill_color   <= i_cfg_data;
                default: ;
            endcase
        end
        if (i_in_valid && i_in_ready) begin
            want.result_pixel = composite_pixel(i_in.src_pixel, i_in.dst_pixel);
            want.last_of_run  = i_in.end_of_run;
            expected_pixels.push_back(want);
        end
        if (i_out_valid && i_out_ready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: result beat %08h arrived with nothing expected",
                         $time, i_out.result_pixel);
                o_errors++;
            end else begin
                want = expected_pixels.pop_front();
                o_checked++;
                if (i_out.result_pixel !== want.result_pixel) begin
                    $display("%0t: result_pixel expected %08h, got %08h",
                             $time, want.result_pixel, i_out.result_pixel);
                    o_errors++;
                end
                if (i_out.last_of_run !== want.last_of_run) begin
                    $display("%0t: last_of_run expected %0b, got %0b",
                             $time, want.last_of_run, i_out.last_of_run);
                    o_errors++;
                end
            end
        end
        o_pending = expected_pixels.size();
    end

endmodule

// ===== verif/tb_argb_premultiplied_compositor.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_argb_premultiplied_compositor
// Drives pixel beats and register settings into the compositor and gives the
// verdict. A short directed set covers the corner cases of every mode, then
// random pixels run under many random settings in three handshake phases.
// ============================================================================
module tb_argb_premultiplied_compositor;
    import argbc_pkg::*;

    localparam logic [1:0] CFG_SPARE     = 2'd3;
    localparam int         CLK_PERIOD    = 10;
    localparam int         RESET_CYCLES  = 11;
    localparam int         STALL_LIMIT   = 5000;
    localparam int         DRAIN_CYCLES  = 8;
    localparam int         RANDOM_BLOCKS = 11;
    localparam int         BLOCK_BEATS   = 48;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_idx   = CFG_MODE;
    logic [31:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_in_beat    in_beat   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_beat   out_beat;

    int tx_idle_pct = 10;
    int rx_idle_pct = 87;
    int beats_sent  = 0;
    int settings_used = 0;
    int idle_cycles = 0;
    int errors;
    int pending;
    int checked;

    always #(CLK_PERIOD / 2) clk = ~clk;

    argb_premultiplied_compositor dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat)
    );

    argbc_pixel_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in        (in_beat),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out       (out_beat),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles.", $time, STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [31:0] rand_premul();
        logic [31:0] px;
        logic [7:0]  a;
        case ($urandom_range(6))
            0:       a = 8'h00;
            1, 2:    a = ALPHA_OPAQUE;
            default: a = 8'($urandom_range(255));
        endcase
        px = {a, 24'h0};
        if ($urandom_range(4) == 0) begin
            px[23:0] = 24'($urandom());
        end else begin
            for (int k = 0; k < 3; k++) begin
                px[8*k +: 8] = 8'($urandom_range(a));
            end
        end
        return px;
    endfunction

    function automatic logic [31:0] rand_pixel();
        return ($urandom_range(3) == 0) ? 32'($urandom()) : rand_premul();
    endfunction

    task automatic push_pixel(input logic [31:0] src, input logic [31:0] dst,
                              input logic eor);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= '{src_pixel: src, dst_pixel: dst, end_of_run: eor};
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        beats_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic [1:0] m, input logic [7:0] ca,
                                 input logic [31:0] color);
        logic [31:0] junk;
        junk = $urandom();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_MODE;
        cfg_data <= {junk[31:2], m};
        @(posedge clk);
        cfg_idx  <= CFG_CONST_ALPHA;
        cfg_data <= {junk[31:8], ca};
        @(posedge clk);
        cfg_idx  <= CFG_SOLID_COLOR;
        cfg_data <= color;
        @(posedge clk);
        cfg_idx  <= CFG_SPARE;
        cfg_data <= junk;
        @(posedge clk);
        cfg_we   <= 1'b0;
        settings_used++;
    endtask

    task automatic random_setting();
        logic [1:0]  m;
        logic [7:0]  ca;
        logic [31:0] color;
        case ($urandom_range(9))
            0, 1, 2: m = MODE_OVER;
            3, 4, 5: m = MODE_INTERP;
            6, 7, 8: m = MODE_SOLID;
            default: m = MODE_NONE;
        endcase
        case ($urandom_range(3))
            0:       ca = 8'h00;
            1:       ca = ALPHA_OPAQUE;
            default: ca = 8'($urandom_range(255));
        endcase
        case ($urandom_range(5))
            0:       color = 32'h0000_0000;
            1:       color = 32'hffff_ffff;
            default: color = rand_pixel();
        endcase
        apply_setting(m, ca, color);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        push_pixel(32'h00ff_ffff, 32'h1234_5678, 1'b1);
        push_pixel(32'hff00_0000, 32'hffff_ffff, 1'b0);
        push_pixel(32'h8040_2010, 32'hff80_8080, 1'b1);
        push_pixel(32'h10ff_80ff, 32'hffff_ffff, 1'b0);
        push_pixel(32'h0000_0000, 32'h0000_0000, 1'b0);
        push_pixel(32'hffff_ffff, 32'hffff_ffff, 1'b1);
        drain_results();

        apply_setting(MODE_OVER, 8'h80, 32'h0000_0000);
        push_pixel(32'h8040_2010, 32'hffff_ffff, 1'b0);
        push_pixel(32'hffff_ffff, 32'h0000_0000, 1'b1);
        push_pixel(32'h00ff_ffff, 32'haabb_ccdd, 1'b0);
        drain_results();

        apply_setting(MODE_INTERP, ALPHA_OPAQUE, 32'hffff_ffff);
        push_pixel(32'h1122_3344, 32'hffff_ffff, 1'b1);
        push_pixel(32'hffff_ffff, 32'h0000_0000, 1'b0);
        drain_results();

        apply_setting(MODE_INTERP, 8'h00, 32'h0000_0000);
        push_pixel(32'hffff_ffff, 32'h0102_0304, 1'b0);
        drain_results();

        apply_setting(MODE_INTERP, 8'h7f, 32'h0000_0000);
        push_pixel(32'hffff_ffff, 32'h0000_0000, 1'b1);
        push_pixel(32'h10ff_80ff, 32'hff00_ff00, 1'b0);
        drain_results();

        apply_setting(MODE_SOLID, ALPHA_OPAQUE, 32'hff10_2030);
        push_pixel(32'h0000_0000, 32'h5555_5555, 1'b1);
        drain_results();

        apply_setting(MODE_SOLID, ALPHA_OPAQUE, 32'h00ff_ffff);
        push_pixel(32'h0000_0000, 32'hffff_ffff, 1'b0);
        drain_results();

        apply_setting(MODE_SOLID, 8'h40, 32'hffff_ffff);
        push_pixel(32'h1234_5678, 32'h8080_8080, 1'b1);
        drain_results();

        apply_setting(MODE_NONE, 8'h33, 32'h0000_0000);
        push_pixel(32'hffff_ffff, 32'hcafe_babe, 1'b0);
        push_pixel(32'h0000_0000, 32'h0000_0000, 1'b1);
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 10;
                    rx_idle_pct = 87;
                end
                1: begin
                    tx_idle_pct = 87;
                    rx_idle_pct = 10;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
                random_setting();
                repeat (BLOCK_BEATS) begin
                    push_pixel(rand_pixel(), rand_pixel(), ($urandom_range(7) == 0));
                end
                drain_results();
            end
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d result beats from %0d pixel beats under %0d register settings.",
                 checked, beats_sent, settings_used);
        $display("Covered all four mode codes with busy, starved and free-running handshakes.");
        if (errors == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
